>>> design/m2h_pkg.sv
// ----------------------------------------------------------------------------
// m2h_pkg
// Shared widths, mixing constants and sequencer states for the
// MurmurHash64A engine.
// ----------------------------------------------------------------------------
package m2h_pkg;

  localparam int unsigned LEN_W  = 31;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned NB_W   = 4;
  localparam int unsigned SEED_W = 32;
  localparam int unsigned HALF_W = 32;

  localparam logic [WORD_W-1:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int unsigned       MIX_SHIFT = 47;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_WORD,
    ST_K1,
    ST_K2,
    ST_ACC,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

>>> design/m2h_ifs.sv
// ----------------------------------------------------------------------------
// m2h interfaces
// Valid/ready channels for message words, hash results and seed writes.
// ----------------------------------------------------------------------------
interface m2h_in_if;
  logic                        valid;
  logic                        ready;
  logic [m2h_pkg::LEN_W-1:0]   message_length;
  logic [m2h_pkg::WORD_W-1:0]  data_word;
  logic [m2h_pkg::NB_W-1:0]    valid_bytes;
  logic                        first_word;
  logic                        last_word;

  modport source (output valid, message_length, data_word, valid_bytes, first_word,
                  last_word, input ready);
  modport sink   (input valid, message_length, data_word, valid_bytes, first_word,
                  last_word, output ready);
endinterface

interface m2h_out_if;
  logic                        valid;
  logic                        ready;
  logic [m2h_pkg::WORD_W-1:0]  hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

interface m2h_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [m2h_pkg::SEED_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> design/murmur2_hash_64.sv
// ----------------------------------------------------------------------------
// murmur2_hash_64
// Streaming MurmurHash64A engine built around one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// Every 64-bit product by the mixing constant runs as three passes through a
// single 32x32 multiplier (low x low, high x low, low x high). A word is taken
// only while the engine is idle, in ST_IDLE, and ST_WORD then dispatches it.
// A full 8-byte word costs three products, a tail of 1 to 7 bytes one product
// and an empty word none. A first word adds the length product, a last word
// adds the final product and a load of the result register. The result
// register lets the next message start while a hash waits to be taken; a
// second hash waits in the engine until the slot frees. Words arriving with
// no open message and no first mark are dropped.
// ----------------------------------------------------------------------------
module murmur2_hash_64 (
  input  logic        clk,
  input  logic        rst_n,
  m2h_in_if.sink      in_ch,
  m2h_out_if.source   out_ch,
  m2h_cfg_if.sink     cfg_ch
);

  localparam logic [m2h_pkg::HALF_W-1:0] M_LO = m2h_pkg::MIX_MUL[31:0];
  localparam logic [m2h_pkg::HALF_W-1:0] M_HI = m2h_pkg::MIX_MUL[63:32];

  m2h_pkg::state_t state_r, state_nxt;

  logic [m2h_pkg::SEED_W-1:0]  seed_r;
  logic [m2h_pkg::WORD_W-1:0]  acc_r, acc_nxt;
  logic [m2h_pkg::WORD_W-1:0]  op_r, op_nxt;
  logic [m2h_pkg::WORD_W-1:0]  prod_r, prod_nxt;
  logic [1:0]                  step_r, step_nxt;
  logic                        in_msg_r, in_msg_nxt;
  logic [m2h_pkg::WORD_W-1:0]  word_r;
  logic                        full_r;
  logic [2:0]                  nb_r;
  logic                        last_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [m2h_pkg::WORD_W-1:0]  out_hash_r, out_hash_nxt;

  logic                        in_xfer;
  logic                        mul_busy;
  logic                        mul_done;
  logic [m2h_pkg::HALF_W-1:0]  mul_a, mul_b;
  logic [m2h_pkg::WORD_W-1:0]  mul_res;
  logic [m2h_pkg::WORD_W-1:0]  prod_done;
  logic [m2h_pkg::WORD_W-1:0]  tail_mask;

  function automatic logic [m2h_pkg::WORD_W-1:0] xsh(input logic [m2h_pkg::WORD_W-1:0] v);
    xsh = v ^ (v >> m2h_pkg::MIX_SHIFT);
  endfunction

  assign in_ch.ready   = (state_r == m2h_pkg::ST_IDLE);
  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.hash_value = out_hash_r;

  // shared multiplier: low 64 bits of op_r * MIX_MUL in three passes
  assign mul_busy = (state_r == m2h_pkg::ST_LEN) || (state_r == m2h_pkg::ST_K1) ||
                    (state_r == m2h_pkg::ST_K2)  || (state_r == m2h_pkg::ST_ACC) ||
                    (state_r == m2h_pkg::ST_FIN);
  assign mul_done = mul_busy && (step_r == 2'd2);
  assign mul_a    = (step_r == 2'd1) ? op_r[63:32] : op_r[31:0];
  assign mul_b    = (step_r == 2'd2) ? M_HI : M_LO;
  assign mul_res  = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    if (step_r == 2'd0) begin
      prod_nxt = mul_res;
    end else begin
      prod_nxt = {prod_r[63:32] + mul_res[31:0], prod_r[31:0]};
    end
  end
  assign prod_done = prod_nxt;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      tail_mask[i*8 +: 8] = (3'(i) < nb_r) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    op_nxt        = op_r;
    in_msg_nxt    = in_msg_r;
    out_valid_nxt = out_valid_r;
    out_hash_nxt  = out_hash_r;
    step_nxt      = (mul_busy && (step_r != 2'd2)) ? step_r + 2'd1 : 2'd0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      m2h_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_ch.first_word) begin
            op_nxt     = {{(m2h_pkg::WORD_W-m2h_pkg::LEN_W){1'b0}}, in_ch.message_length};
            in_msg_nxt = !in_ch.last_word;
            state_nxt  = m2h_pkg::ST_LEN;
          end else if (in_msg_r) begin
            in_msg_nxt = !in_ch.last_word;
            state_nxt  = m2h_pkg::ST_WORD;
          end
        end
      end
      m2h_pkg::ST_LEN: begin
        if (mul_done) begin
          acc_nxt   = {32'd0, seed_r} ^ prod_done;
          state_nxt = m2h_pkg::ST_WORD;
        end
      end
      m2h_pkg::ST_WORD: begin
        if (full_r) begin
          op_nxt    = word_r;
          state_nxt = m2h_pkg::ST_K1;
        end else if (nb_r != 3'd0) begin
          op_nxt    = acc_r ^ (word_r & tail_mask);
          state_nxt = m2h_pkg::ST_ACC;
        end else if (last_r) begin
          op_nxt    = xsh(acc_r);
          state_nxt = m2h_pkg::ST_FIN;
        end else begin
          state_nxt = m2h_pkg::ST_IDLE;
        end
      end
      m2h_pkg::ST_K1: begin
        if (mul_done) begin
          op_nxt    = xsh(prod_done);
          state_nxt = m2h_pkg::ST_K2;
        end
      end
      m2h_pkg::ST_K2: begin
        if (mul_done) begin
          op_nxt    = acc_r ^ prod_done;
          state_nxt = m2h_pkg::ST_ACC;
        end
      end
      m2h_pkg::ST_ACC: begin
        if (mul_done) begin
          acc_nxt = prod_done;
          if (last_r) begin
            op_nxt    = xsh(prod_done);
            state_nxt = m2h_pkg::ST_FIN;
          end else begin
            state_nxt = m2h_pkg::ST_IDLE;
          end
        end
      end
      m2h_pkg::ST_FIN: begin
        if (mul_done) begin
          state_nxt = m2h_pkg::ST_OUT;
        end
      end
      m2h_pkg::ST_OUT: begin
        // prod_r holds the final product; wait for a free result slot
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = xsh(prod_r);
          state_nxt     = m2h_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = m2h_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= m2h_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= '0;
      acc_r       <= '0;
      in_msg_r    <= 1'b0;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        seed_r <= cfg_ch.data;
      end
      acc_r       <= acc_nxt;
      in_msg_r    <= in_msg_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    out_hash_r <= out_hash_nxt;
    if (mul_busy) begin
      prod_r <= prod_nxt;
    end
    if (in_xfer) begin
      word_r <= in_ch.data_word;
      full_r <= in_ch.valid_bytes[3];
      nb_r   <= in_ch.valid_bytes[2:0];
      last_r <= in_ch.last_word;
    end
  end

endmodule
